@@ sv/whpi_pkg.sv @@
// Package for the word hash probe inserter: states, status codes, register indexes.
// No dependencies.
`timescale 1ns / 1ps
package whpi_pkg;
    localparam int TABLE_SLOTS_DEF  = 1024;
    localparam int MAX_WORD_LEN_DEF = 32;
    localparam logic [31:0] SEED_RESET = 32'd1233;
    localparam logic [31:0] HASH_MULT  = 32'd33;

    typedef enum logic [1:0] {
        ST_NEW  = 2'd0,
        ST_DUP  = 2'd1,
        ST_FULL = 2'd2,
        ST_LONG = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        REG_SIZE = 2'd0,
        REG_MODE = 2'd1,
        REG_SEED = 2'd2
    } t_reg;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_MOD, S_PROBE, S_LEN, S_CMP, S_CMPW, S_WRITE, S_NEXT, S_OUT
    } t_state;
endpackage

@@ sv/word_hash_probe_inserter_top.sv @@
// Word hash probe inserter top level: word builder, hash, modulo unit, probe walk.
// Depends on whpi_pkg.
`timescale 1ns / 1ps
// Letters are taken while idle. A word end runs a bit-serial modulo of the folded
// hash; each probe reads the slot length and compares the letters, a passed slot
// steps to the next probe, and a new word is stored letter by letter, then its
// length; the result register is loaded last. Input stalls during a word end and
// while a result waits. Reset is synchronous; all TABLE_SLOTS slot lengths (1024
// by default) are then cleared, one per cycle, before the first request is taken.
module word_hash_probe_inserter_top
    import whpi_pkg::*;
#(
    parameter int TABLE_SLOTS  = TABLE_SLOTS_DEF,
    parameter int MAX_WORD_LEN = MAX_WORD_LEN_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // text_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status[1:0], slot_index[11:2], probes_used[22:12], collision_total[54:23],
    // folded_hash[86:55], letters_in_word[92:87], zero fill to 96
    output logic [95:0] m_axis_tdata,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);
    localparam int SW = $clog2(TABLE_SLOTS);
    localparam int LW = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
    localparam int AW = SW + LW;
    localparam int PW = SW + 1;

    // config
    logic [10:0] r_size;
    logic        r_mode;
    logic [31:0] r_seed;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= 11'd1024; r_mode <= 1'b0; r_seed <= SEED_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SIZE: r_size <= i_cfg_data[10:0];
                REG_MODE: r_mode <= i_cfg_data[0];
                REG_SEED: r_seed <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // effective size
    logic [PW:0] eff;
    always_comb begin
        if (r_size < 11'd2) eff = (PW+1)'(2);
        else if (32'(r_size) > 32'(TABLE_SLOTS)) eff = (PW+1)'(TABLE_SLOTS);
        else eff = (PW+1)'(r_size);
    end

    t_state r_st, n_st;
    logic [5:0]  r_len;
    logic        r_long;
    logic [31:0] r_hash;
    logic [31:0] r_coll;
    logic [31:0] r_fold;
    logic [PW:0] r_rem;
    logic [5:0]  r_bit;
    logic [PW:0] r_h, r_slot, r_i, r_off;
    logic [5:0]  r_j;
    t_status     r_status;
    logic [95:0] r_out;
    logic        r_ov;
    logic [SW-1:0] r_clr;

    // memories
    logic [7:0] word_buf [MAX_WORD_LEN];
    logic [7:0] slot_mem [2**AW];
    logic [5:0] slen_mem [TABLE_SLOTS];
    logic [7:0] r_mem_q, r_buf_q;
    logic [5:0] r_slen_q;

    // byte decode
    logic [7:0] ch, letter;
    logic is_let, is_ws;
    always_comb begin
        ch = s_axis_tdata;
        letter = 8'd0;
        if (ch >= 8'h41 && ch <= 8'h5A) letter = ch + 8'h20;
        else if (ch >= 8'h61 && ch <= 8'h7A) letter = ch;
        is_let = (letter != 8'd0);
        is_ws = (ch == 8'h20) || (ch == 8'h0A) || (ch == 8'h09);
    end

    // result register free: empty or being taken this cycle
    logic out_free;
    assign out_free = !r_ov || m_axis_tready;

    assign s_axis_tready = (r_st == S_IDLE);
    logic acc;
    assign acc = s_axis_tvalid && s_axis_tready;

    logic [31:0] hbase;
    assign hbase = (r_len == 6'd0) ? r_seed : r_hash;

    // slot address for reads / writes; the buffer read runs one letter ahead while storing
    logic [SW-1:0] slot_a;
    logic [LW-1:0] j_a, jb_a;
    logic [5:0]    j_nx;
    logic [AW-1:0] mem_a;
    assign slot_a = r_slot[SW-1:0];
    assign j_a = r_j[LW-1:0];
    assign j_nx = r_j + 6'd1;
    assign jb_a = (r_st == S_WRITE) ? j_nx[LW-1:0] : r_j[LW-1:0];
    assign mem_a = {slot_a, j_a};

    // slot length port: cleared after reset, written when a word is stored
    logic          slen_we;
    logic [SW-1:0] slen_wa;
    logic [5:0]    slen_wd;
    assign slen_we = (r_st == S_CLR) || (r_st == S_WRITE && r_j >= r_len);
    assign slen_wa = (r_st == S_CLR) ? r_clr : slot_a;
    assign slen_wd = (r_st == S_CLR) ? 6'd0 : r_len;

    always_ff @(posedge i_clk) begin
        if (acc && is_let && 32'(r_len) < 32'(MAX_WORD_LEN))
            word_buf[r_len[LW-1:0]] <= letter;
        if (r_st == S_WRITE && r_j < r_len)
            slot_mem[mem_a] <= r_buf_q;
        r_mem_q <= slot_mem[mem_a];
        r_buf_q <= word_buf[jb_a];
        if (slen_we) slen_mem[slen_wa] <= slen_wd;
        r_slen_q <= slen_mem[slot_a];
    end

    // next state
    always_comb begin
        n_st = r_st;
        case (r_st)
            S_CLR:   if (r_clr == SW'(TABLE_SLOTS - 1)) n_st = S_IDLE;
            S_IDLE:  if (acc && !is_let && is_ws && r_len != 6'd0)
                         n_st = r_long ? S_OUT : S_MOD;
            S_MOD:   if (r_bit == 6'd0) n_st = S_PROBE;
            S_PROBE: n_st = S_LEN;
            S_LEN:   if (r_i == eff) n_st = S_OUT;
                     else if (r_slen_q == 6'd0) n_st = S_WRITE;
                     else if (r_slen_q == r_len) n_st = S_CMP;
                     else n_st = S_NEXT;
            S_CMP:   n_st = S_CMPW;
            S_CMPW:  if (r_mem_q != r_buf_q) n_st = S_NEXT;
                     else if (r_j + 6'd1 >= r_len) n_st = S_OUT;
                     else n_st = S_CMP;
            S_WRITE: if (r_j >= r_len) n_st = S_OUT;
            S_NEXT:  n_st = (r_i + 1'b1 == eff) ? S_OUT : S_PROBE;
            S_OUT:   if (out_free) n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    // datapath; quadratic step 2i+1 is kept reduced modulo the size
    logic [PW+1:0] sum, sum2;
    logic [PW:0] inc, off_up;
    always_comb begin
        inc    = r_mode ? r_off : (PW+1)'(1);
        off_up = r_off + (PW+1)'(2);
        sum    = {1'b0, r_slot} + {1'b0, inc};
        sum2   = sum - {1'b0, eff};
    end

    logic [PW+1:0] rem2;
    assign rem2 = {r_rem, r_fold[r_bit[4:0]]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_CLR; r_clr <= '0; r_len <= '0; r_long <= 1'b0;
            r_hash <= SEED_RESET; r_coll <= '0; r_ov <= 1'b0;
        end else begin
            r_st <= n_st;
            if (r_st == S_OUT && out_free) r_ov <= 1'b1;
            else if (m_axis_tready) r_ov <= 1'b0;
            case (r_st)
                S_CLR: r_clr <= r_clr + 1'b1;
                S_IDLE: if (acc) begin
                    if (is_let) begin
                        r_hash <= hbase * HASH_MULT + 32'(letter);
                        if (32'(r_len) >= 32'(MAX_WORD_LEN)) r_long <= 1'b1;
                        if (r_len != 6'd63) r_len <= r_len + 6'd1;
                    end else if (is_ws && r_len != 6'd0) begin
                        r_fold <= r_hash[31] ? (32'd1 - r_hash) : r_hash;
                        r_rem <= '0; r_bit <= 6'd31;
                        r_status <= r_long ? ST_LONG : ST_FULL;
                        r_i <= '0; r_slot <= '0; r_off <= (PW+1)'(1);
                    end
                end
                S_MOD: begin
                    if (rem2 >= {1'b0, eff}) r_rem <= (PW+1)'(rem2 - {1'b0, eff});
                    else r_rem <= rem2[PW:0];
                    r_bit <= r_bit - 6'd1;
                    if (r_bit == 6'd0) begin
                        if (rem2 >= {1'b0, eff}) r_slot <= (PW+1)'(rem2 - {1'b0, eff});
                        else r_slot <= rem2[PW:0];
                    end
                end
                S_PROBE: r_j <= '0;
                S_LEN: ;
                S_CMP: ;
                S_CMPW: if (r_mem_q == r_buf_q) begin
                    r_j <= r_j + 6'd1;
                    if (r_j + 6'd1 >= r_len) r_status <= ST_DUP;
                end
                S_WRITE: begin
                    r_j <= r_j + 6'd1;
                    if (r_j >= r_len) r_status <= ST_NEW;
                end
                S_NEXT: begin
                    r_i <= r_i + 1'b1;
                    if (r_coll != 32'hFFFF_FFFF) r_coll <= r_coll + 32'd1;
                    r_slot <= sum >= {1'b0, eff} ? sum2[PW:0] : sum[PW:0];
                    r_off <= (off_up >= eff) ? off_up - eff : off_up;
                end
                S_OUT: if (out_free) begin
                    r_len <= '0; r_long <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    // zero-length duplicate check does not occur: words have at least one letter
    logic [9:0] slot_o;
    logic [10:0] prb_o;
    always_comb begin
        slot_o = (r_status == ST_NEW || r_status == ST_DUP) ? 10'(r_slot) : 10'd0;
        prb_o = (r_status == ST_LONG) ? 11'd0 : 11'(r_i);
    end
    always_ff @(posedge i_clk) begin
        if (r_st == S_OUT && out_free)
            r_out <= {3'd0, r_len, r_fold, r_coll, prb_o, slot_o, r_status};
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata = r_out;

    // a finished result holds until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && !m_axis_tready |=> r_ov && $stable(r_out))
        else $error("result lost");
    // no input taken while busy
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st != S_IDLE |-> !s_axis_tready)
        else $error("ready while busy");
    // probe index never exceeds table size
    a_prb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == S_LEN |-> r_i <= eff)
        else $error("probe overrun");
endmodule
